### design/urjf_pkg.sv
// Shared types and constants of the ultrasonic ranger with jump filter.
package urjf_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_CM_PER_TICK = 2'd0;
    localparam logic [1:0] REG_JUMP_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TRIG_TICKS  = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] CM_PER_TICK_RESET = 16'd1124;
    localparam logic [15:0] JUMP_LIMIT_RESET  = 16'd50;
    localparam logic [15:0] TRIG_TICKS_RESET  = 16'd10;

    // Fixed field widths.
    localparam int TRIG_BITS = 7;
    localparam int DIST_BITS = 16;

    // Measurement phases.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    // Input item without the command flag, most significant member first.
    typedef struct packed {
        logic       echo;
        logic       reset_filter;
        logic [2:0] channel;
    } in_fields_t;

    // One input item.
    typedef struct packed {
        logic       cmd;
        in_fields_t fields;
    } in_item_t;

    // Outcome of the sequencer for one item, passed down the pipeline.
    typedef struct packed {
        logic [TRIG_BITS-1:0] trig_lines;
        logic                 busy;
        logic                 done;
        logic [2:0]           channel;
        logic                 ignored;
        logic                 unfiltered;
    } ctrl_res_t;

    // One result item, most significant member first.
    typedef struct packed {
        logic                 start_ignored;
        logic [DIST_BITS-1:0] distance_cm;
        logic [2:0]           done_channel;
        logic                 done_res;
        logic                 busy_res;
        logic [TRIG_BITS-1:0] trigger_lines;
    } out_item_t;

endpackage

### design/ultrasonic_ranger_with_jump_filter_core.sv
// Multi-channel ultrasonic ranger with an upward jump filter. Each input
// transaction is either a tick (one sample of the shared echo line) or a start
// command that picks a channel; every input transaction yields exactly one
// result transaction, in order. The block takes one transaction per clock
// cycle while the result side is ready, and each result passes through the input
// register, sequencer register, product register, then the filter into the
// result register; back-pressure on the result side stalls the pipeline stage
// by stage. The rate is set by the sequencer, which updates phase and tick
// count for one transaction per cycle.
// The user must write configuration through the cfg port only while no
// transaction is in flight; the block itself does not enforce this.
module ultrasonic_ranger_with_jump_filter_core import urjf_pkg::*; #(
    parameter int CHANNELS   = 7,
    parameter int COUNT_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // channel[2:0], reset_filter[3], echo[4], zero fill
    input  logic        s_tuser,  // cmd: 0 = tick, 1 = start
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // trigger_lines[6:0], busy_res[7], done_res[8],
                                  // done_channel[11:9], distance_cm[27:12],
                                  // start_ignored[28], zero fill
);

    logic [15:0]            cm_per_tick_reg;
    logic [15:0]            jump_limit_reg;
    logic [15:0]            trig_ticks_reg;

    logic                   in_valid_reg, in_valid_next;
    in_item_t               in_item_reg;
    logic                   in_load;

    logic                   ctrl_in_ready;
    logic                   ctrl_valid;
    ctrl_res_t              ctrl_res;
    logic [COUNT_BITS-1:0]  ctrl_count;

    logic                   scale_in_ready;
    logic                   scale_valid;
    ctrl_res_t              scale_res;
    logic [COUNT_BITS+15:0] scale_product;

    logic                   filt_in_ready;
    out_item_t              result;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cm_per_tick_reg <= CM_PER_TICK_RESET;
            jump_limit_reg  <= JUMP_LIMIT_RESET;
            trig_ticks_reg  <= TRIG_TICKS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CM_PER_TICK: cm_per_tick_reg <= cfg_wdata;
                REG_JUMP_LIMIT:  jump_limit_reg  <= cfg_wdata;
                REG_TRIG_TICKS:  trig_ticks_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    assign s_tready = !in_valid_reg || ctrl_in_ready;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (ctrl_in_ready) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg.cmd    <= s_tuser;
            in_item_reg.fields <= s_tdata[$bits(in_fields_t)-1:0];
        end
    end

    urjf_ctrl #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .trigger_ticks (trig_ticks_reg),
        .in_valid      (in_valid_reg),
        .in_ready      (ctrl_in_ready),
        .in_item       (in_item_reg),
        .out_valid     (ctrl_valid),
        .out_ready     (scale_in_ready),
        .out_res       (ctrl_res),
        .out_count     (ctrl_count)
    );

    urjf_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scale (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cm_per_tick_q16 (cm_per_tick_reg),
        .in_valid        (ctrl_valid),
        .in_ready        (scale_in_ready),
        .in_res          (ctrl_res),
        .in_count        (ctrl_count),
        .out_valid       (scale_valid),
        .out_ready       (filt_in_ready),
        .out_res         (scale_res),
        .out_product     (scale_product)
    );

    urjf_filter #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_filter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .jump_limit_cm (jump_limit_reg),
        .in_valid      (scale_valid),
        .in_ready      (filt_in_ready),
        .in_res        (scale_res),
        .in_product    (scale_product),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_item      (result)
    );

    // Result packing with zero fill to whole bytes.
    assign m_tdata = {(32 - $bits(out_item_t))'(0), result};

endmodule

### design/urjf_ctrl.sv
// Measurement sequencer: phases, trigger timing and echo tick counting.
module urjf_ctrl import urjf_pkg::*; #(
    parameter int CHANNELS   = 7,
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [15:0]           trigger_ticks,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ctrl_res_t             out_res,
    output logic [COUNT_BITS-1:0] out_count
);

    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    phase_t                phase_reg, phase_next;
    logic [2:0]            active_ch_reg, active_ch_next;
    logic                  pending_reg, pending_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [15:0]           limit;
    logic                  valid_reg, valid_next;
    ctrl_res_t             res_reg, res_next;
    logic [COUNT_BITS-1:0] done_count_reg, done_count_next;
    logic                  load;

    // Stage handshake: the register takes a transaction when empty or draining.
    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_count = done_count_reg;

    assign limit     = (trigger_ticks == 16'd0) ? 16'd1 : trigger_ticks;
    assign count_inc = count_reg + COUNT_BITS'(1);

    // Next state and per-item outcome.
    always_comb begin
        phase_next      = phase_reg;
        active_ch_next  = active_ch_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        res_next        = '0;
        done_count_next = '0;
        if (load) begin
            if (in_item.cmd) begin
                if (phase_reg != PH_IDLE || {2'b00, in_item.fields.channel} >= CH_LIMIT) begin
                    res_next.ignored = 1'b1;
                end else begin
                    phase_next     = PH_TRIG;
                    active_ch_next = in_item.fields.channel;
                    pending_next   = in_item.fields.reset_filter;
                    count_next     = '0;
                end
            end else begin
                case (phase_reg)
                    PH_TRIG: begin
                        res_next.trig_lines = TRIG_BITS'(1) << active_ch_reg;
                        if (count_inc >= COUNT_BITS'(limit)) begin
                            phase_next = PH_WAIT;
                            count_next = '0;
                        end else begin
                            count_next = count_inc;
                        end
                    end
                    PH_WAIT: begin
                        if (in_item.fields.echo) begin
                            phase_next = PH_MEAS;
                            count_next = COUNT_BITS'(1);
                        end
                    end
                    PH_MEAS: begin
                        if (in_item.fields.echo) begin
                            if (count_reg != '1) begin
                                count_next = count_inc;
                            end
                        end else begin
                            res_next.done    = 1'b1;
                            res_next.channel = active_ch_reg;
                            done_count_next  = count_reg;
                            phase_next       = PH_IDLE;
                            count_next       = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            res_next.busy       = (phase_next != PH_IDLE);
            res_next.unfiltered = pending_reg;
        end
    end

    // Valid flag of the stage register.
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            active_ch_reg <= '0;
            pending_reg   <= 1'b0;
            count_reg     <= '0;
            valid_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            active_ch_reg <= active_ch_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg        <= res_next;
            done_count_reg <= done_count_next;
        end
    end

`ifndef SYNTH
    // At most one trigger line is ever driven.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> $onehot0(res_reg.trig_lines))
        else $error("more than one trigger line high");

    // A delivered distance always ends the measurement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.done) |-> !res_reg.busy)
        else $error("busy after a delivered distance");

    // A dropped start never delivers a distance or drives a trigger.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.ignored) |-> (!res_reg.done && res_reg.trig_lines == '0))
        else $error("dropped start produced output");

    // The tick counter is clear whenever the block is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("tick counter not clear while idle");
`endif

endmodule

### design/urjf_scale.sv
// Scaling stage: multiplies the echo tick count by the Q16 centimetre factor.
module urjf_scale import urjf_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [15:0]              cm_per_tick_q16,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ctrl_res_t                in_res,
    input  logic [COUNT_BITS-1:0]    in_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ctrl_res_t                out_res,
    output logic [COUNT_BITS+15:0]   out_product
);

    logic                   valid_reg, valid_next;
    ctrl_res_t              res_reg;
    logic [COUNT_BITS+15:0] product_reg, product_next;
    logic                   load;

    assign in_ready    = !valid_reg || out_ready;
    assign load        = in_valid && in_ready;
    assign out_valid   = valid_reg;
    assign out_res     = res_reg;
    assign out_product = product_reg;

    // Raw product; the count is zero unless a distance is delivered.
    assign product_next = (COUNT_BITS + 16)'(in_count) * (COUNT_BITS + 16)'(cm_per_tick_q16);

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg     <= in_res;
            product_reg <= product_next;
        end
    end

endmodule

### design/urjf_filter.sv
// Jump filter stage: saturates the distance, applies the per-channel upward jump limit
// and holds the result register.
module urjf_filter import urjf_pkg::*; #(
    parameter int CHANNELS   = 7,
    parameter int COUNT_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [15:0]            jump_limit_cm,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ctrl_res_t              in_res,
    input  logic [COUNT_BITS+15:0] in_product,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item
);

    // The channel field is three bits wide, so at most eight channels are stored.
    localparam int STORE_DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int STORE_IDX   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [DIST_BITS-1:0] prev_reg [STORE_DEPTH];
    logic [STORE_IDX-1:0] idx;
    logic [DIST_BITS-1:0] cur;
    logic [DIST_BITS-1:0] prev;
    logic [DIST_BITS:0]   raised;
    logic [DIST_BITS-1:0] raised_sat;
    logic                 hold;
    logic [DIST_BITS-1:0] store_val;
    logic                 valid_reg, valid_next;
    out_item_t            item_reg, item_next;
    logic                 load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign idx = in_res.channel[STORE_IDX-1:0];

    // Truncated Q16 product, saturated to the distance range.
    assign cur = ((in_product >> 32) != '0) ? '1 : in_product[31:16];

    // On a too-far upward jump, report the stored value and raise it by the limit.
    assign prev       = prev_reg[idx];
    assign hold       = !in_res.unfiltered && (cur > prev) && ((cur - prev) > jump_limit_cm);
    assign raised     = {1'b0, prev} + {1'b0, jump_limit_cm};
    assign raised_sat = raised[DIST_BITS] ? '1 : raised[DIST_BITS-1:0];
    assign store_val  = hold ? raised_sat : cur;

    // Result transaction.
    always_comb begin
        item_next               = '0;
        item_next.trigger_lines = in_res.trig_lines;
        item_next.busy_res      = in_res.busy;
        item_next.start_ignored = in_res.ignored;
        if (in_res.done) begin
            item_next.done_res     = 1'b1;
            item_next.done_channel = in_res.channel;
            item_next.distance_cm  = hold ? prev : cur;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    // Stored distance per channel, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                prev_reg[i] <= '0;
            end
        end else if (load && in_res.done) begin
            prev_reg[idx] <= store_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

endmodule
